// File: hw/rtl/jce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON content extractor package
// Shared types, register indexes and constants of the content extractor.
// ----------------------------------------------------------------------------
package jce_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_line;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       content_done;
    logic       key_found;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic        event_stream_mode;
    logic [15:0] output_limit;
  } cfg_t;

  // One input byte's worth of results: up to three bytes and the closing flags.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n;
    logic            closed;
    logic            key;
  } run_t;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_DECODE = 4'b0010,
    PH_CLOSED = 4'b0100,
    PH_ENDED  = 4'b1000
  } phase_t;

  localparam logic REG_EVENT_STREAM_MODE = 1'b0;
  localparam logic REG_OUTPUT_LIMIT      = 1'b1;

  localparam logic [15:0] OUTPUT_LIMIT_RESET = 16'd8191;

  localparam int RUN_FIFO_DEPTH = 4;
  localparam int RUN_PTR_W      = $clog2(RUN_FIFO_DEPTH);

  localparam logic [2:0] PREFIX_LEN = 3'd6;
  localparam logic [3:0] KEY_LEN    = 4'd11;

  localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
  localparam logic [7:0]  UTF8_CONT      = 8'h80;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NUL       = 8'h00;

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = "d";
      3'd1:    c = "a";
      3'd2:    c = "t";
      3'd3:    c = "a";
      3'd4:    c = ":";
      3'd5:    c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = CH_QUOTE;
      4'd1:    c = "c";
      4'd2:    c = "o";
      4'd3:    c = "n";
      4'd4:    c = "t";
      4'd5:    c = "e";
      4'd6:    c = "n";
      4'd7:    c = "t";
      4'd8:    c = CH_QUOTE;
      4'd9:    c = ":";
      4'd10:   c = CH_QUOTE;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/json_content_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON content extractor
// Finds the "content" string in each line and streams out its decoded bytes.
// ----------------------------------------------------------------------------
// The block takes one line byte per cycle unless the run queue is full and
// returns the decoded bytes of its "content" string, one result per cycle
// while results are popped. A byte that yields k results (k is 0 to 3; a
// unicode escape may give three) holds the result port until all k are taken,
// so input runs at one byte per cycle while results keep pace; a four-entry
// run queue between decoder and result sequencer absorbs short bursts. The
// user is to write configuration between lines; the block does not enforce it.
module json_content_extractor (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  jce_pkg::in_t  in_data,
  output logic          out_empty,
  input  logic          out_pop,
  output jce_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_wdata
);

  jce_pkg::cfg_t cfg_r;
  jce_pkg::cfg_t cfg_nxt;
  logic          accept;
  logic          run_push;
  jce_pkg::run_t run_in;
  jce_pkg::run_t run_head;
  logic          run_full;
  logic          run_valid;
  logic          run_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        jce_pkg::REG_EVENT_STREAM_MODE: cfg_nxt.event_stream_mode = cfg_wdata[0];
        jce_pkg::REG_OUTPUT_LIMIT:      cfg_nxt.output_limit      = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.event_stream_mode <= 1'b0;
      cfg_r.output_limit      <= jce_pkg::OUTPUT_LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = run_full;
  assign accept  = in_push && !run_full;

  jce_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .accept   (accept),
    .item     (in_data),
    .run_push (run_push),
    .run      (run_in)
  );

  jce_run_fifo u_run_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (run_push),
    .wdata     (run_in),
    .pop       (run_pop),
    .rdata     (run_head),
    .full      (run_full),
    .not_empty (run_valid)
  );

  jce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (run_head),
    .head_valid (run_valid),
    .head_pop   (run_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_data   (out_data)
  );

  assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result port not empty after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.content_done |-> out_data.last_of_run)
    else $error("content_done on a result that does not end its run");

  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_data.byte_valid |-> out_data.out_byte == 8'h00 && out_data.content_done)
    else $error("empty result that neither closes nor carries zero");

  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.byte_valid |-> out_data.key_found)
    else $error("decoded byte before the key was matched");

endmodule

// File: hw/rtl/jce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON content extractor front end
// Tracks the prefix, the key match and the string decoder of the current line
// and turns each accepted byte into one run of up to three result bytes.
// ----------------------------------------------------------------------------
module jce_front (
  input  logic          clk,
  input  logic          rst_n,
  input  jce_pkg::cfg_t cfg,
  input  logic          accept,
  input  jce_pkg::in_t  item,
  output logic          run_push,
  output jce_pkg::run_t run
);

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n;
    logic [15:0]     cnt;
  } acc_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] val;
    logic       esc;
    logic       start_u;
  } dec_t;

  function automatic acc_t append(input acc_t a, input logic [7:0] v);
    acc_t r;
    r = a;
    if (a.n != 2'd3) begin
      r.bytes[a.n] = v;
      r.n          = a.n + 2'd1;
      r.cnt        = a.cnt + 16'd1;
    end
    return r;
  endfunction

  function automatic dec_t dec_char(input logic esc, input logic [7:0] b,
                                    input logic allow_u);
    dec_t d;
    d = '{emit: 1'b0, val: b, esc: esc, start_u: 1'b0};
    if (esc) begin
      d.esc  = 1'b0;
      d.emit = 1'b1;
      case (b)
        "n":     d.val = 8'h0A;
        "r":     d.val = 8'h0D;
        "t":     d.val = 8'h09;
        "b":     d.val = 8'h08;
        "f":     d.val = 8'h0C;
        "u": begin
          d.emit    = 1'b0;
          d.start_u = allow_u;
        end
        default: d.val = b;
      endcase
    end else if (b == jce_pkg::CH_BACKSLASH) begin
      d.esc = 1'b1;
    end else begin
      d.emit = 1'b1;
    end
    return d;
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    if (b >= "0" && b <= "9") r = {1'b1, 4'(b - "0")};
    else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - "a" + 8'd10)};
    else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - "A" + 8'd10)};
    else r = 5'd0;
    return r;
  endfunction

  function automatic logic [3:0] key_next(input logic [3:0] p, input logic [7:0] b);
    logic [3:0] r;
    if (p < jce_pkg::KEY_LEN && b == jce_pkg::key_char(p)) r = p + 4'd1;
    else if (p == 4'd9 && b == "c") r = 4'd2;
    else if (b == jce_pkg::CH_QUOTE) r = 4'd1;
    else r = 4'd0;
    return r;
  endfunction

  function automatic logic [7:0] pick_byte(input logic [23:0] v, input logic [1:0] j);
    logic [7:0] r;
    case (j)
      2'd0:    r = v[7:0];
      2'd1:    r = v[15:8];
      default: r = v[23:16];
    endcase
    return r;
  endfunction

  logic [2:0]       pfx_pos_r, pfx_pos_nxt;
  logic             pfx_fail_r, pfx_fail_nxt;
  logic [3:0]       key_pos_r, key_pos_nxt;
  jce_pkg::phase_t  phase_r, phase_nxt;
  logic             esc_r, esc_nxt;
  logic [2:0]       hex_cnt_r, hex_cnt_nxt;
  logic [23:0]      hex_chars_r, hex_chars_nxt;
  logic [15:0]      emit_cnt_r, emit_cnt_nxt;
  logic             scan_esc_r, scan_esc_nxt;

  acc_t             acc;
  dec_t             dc;
  logic [7:0]       b;
  logic [7:0]       ch;
  logic [7:0]       dig [4];
  logic [4:0]       hv;
  logic [15:0]      cp;
  logic             stop;
  logic             ends;
  logic             closed;
  logic             do_flush;
  logic [1:0]       nf;
  logic [3:0]       kp;
  jce_pkg::phase_t  phase_v;
  logic             esc_v;
  logic [2:0]       hex_cnt_v;
  logic [23:0]      hex_chars_v;

  always_comb begin
    b           = item.in_byte;
    pfx_pos_nxt = pfx_pos_r;
    pfx_fail_nxt = pfx_fail_r;
    key_pos_nxt = key_pos_r;
    phase_v     = phase_r;
    esc_v       = esc_r;
    hex_cnt_v   = hex_cnt_r;
    hex_chars_v = hex_chars_r;
    scan_esc_nxt = scan_esc_r;
    acc         = '{bytes: '0, n: 2'd0, cnt: emit_cnt_r};
    dc          = '0;
    ch          = 8'h00;
    hv          = 5'd0;
    cp          = 16'd0;
    stop        = 1'b0;
    ends        = 1'b0;
    closed      = 1'b0;
    nf          = 2'd0;
    kp          = 4'd0;
    dig[0]      = hex_chars_r[23:16];
    dig[1]      = hex_chars_r[15:8];
    dig[2]      = hex_chars_r[7:0];
    dig[3]      = b;

    unique case (phase_r)
      jce_pkg::PH_SEARCH: begin
        if (cfg.event_stream_mode && !pfx_fail_r && pfx_pos_r < jce_pkg::PREFIX_LEN) begin
          if (b == jce_pkg::prefix_char(pfx_pos_r)) pfx_pos_nxt = pfx_pos_r + 3'd1;
          else pfx_fail_nxt = 1'b1;
        end else if (!cfg.event_stream_mode || !pfx_fail_r) begin
          if (b == jce_pkg::CH_NUL) begin
            phase_v = jce_pkg::PH_ENDED;
          end else begin
            kp = key_next(key_pos_r, b);
            if (kp >= jce_pkg::KEY_LEN) begin
              key_pos_nxt  = 4'd0;
              phase_v      = jce_pkg::PH_DECODE;
              esc_v        = 1'b0;
              scan_esc_nxt = 1'b0;
              hex_cnt_v    = 3'd0;
              hex_chars_v  = 24'd0;
            end else begin
              key_pos_nxt = kp;
            end
          end
        end
      end
      jce_pkg::PH_DECODE: begin
        ends = (b == jce_pkg::CH_NUL) || (!scan_esc_r && b == jce_pkg::CH_QUOTE);
        scan_esc_nxt = scan_esc_r ? 1'b0 : (b == jce_pkg::CH_BACKSLASH);
        if (ends) begin
          phase_v = jce_pkg::PH_CLOSED;
          closed  = 1'b1;
        end else if (hex_cnt_r != 3'd0) begin
          if (hex_cnt_r < 3'd4) begin
            hex_chars_v = {hex_chars_r[15:0], b};
            hex_cnt_v   = hex_cnt_r + 3'd1;
          end else begin
            hex_cnt_v = 3'd0;
            for (int i = 0; i < 4; i++) begin
              hv = hex_val(dig[i]);
              if (!stop) begin
                if (hv[4]) cp = {cp[11:0], hv[3:0]};
                else stop = 1'b1;
              end
            end
            if (cp < jce_pkg::UTF8_ONE_LIMIT) begin
              acc = append(acc, cp[7:0]);
            end else if (cp < jce_pkg::UTF8_TWO_LIMIT) begin
              if ({1'b0, acc.cnt} + 17'd2 < {1'b0, cfg.output_limit}) begin
                acc = append(acc, jce_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]});
                acc = append(acc, jce_pkg::UTF8_CONT | {2'b00, cp[5:0]});
              end
            end else if ({1'b0, acc.cnt} + 17'd3 < {1'b0, cfg.output_limit}) begin
              acc = append(acc, jce_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]});
              acc = append(acc, jce_pkg::UTF8_CONT | {2'b00, cp[11:6]});
              acc = append(acc, jce_pkg::UTF8_CONT | {2'b00, cp[5:0]});
            end
          end
        end else if (acc.cnt < cfg.output_limit) begin
          dc    = dec_char(esc_r, b, 1'b1);
          esc_v = dc.esc;
          if (dc.emit) acc = append(acc, dc.val);
          if (dc.start_u) begin
            hex_cnt_v   = 3'd1;
            hex_chars_v = 24'd0;
          end
        end
      end
      jce_pkg::PH_CLOSED: begin
      end
      jce_pkg::PH_ENDED: begin
      end
      default: begin
      end
    endcase

    // The string or the line ended while a unicode escape was still collecting: the
    // gathered characters are decoded as plain text.
    do_flush = ends || (item.end_of_line && phase_v == jce_pkg::PH_DECODE);
    if (do_flush && hex_cnt_v != 3'd0) begin
      nf        = hex_cnt_v[1:0] - 2'd1;
      hex_cnt_v = 3'd0;
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < nf) begin
          ch = pick_byte(hex_chars_v, nf - 2'd1 - 2'(k));
          if (acc.cnt < cfg.output_limit) begin
            dc    = dec_char(esc_v, ch, 1'b0);
            esc_v = dc.esc;
            if (dc.emit) acc = append(acc, dc.val);
          end
        end
      end
    end
    if (item.end_of_line) closed = 1'b1;

    run.bytes  = acc.bytes;
    run.n      = acc.n;
    run.closed = closed;
    run.key    = (phase_v == jce_pkg::PH_DECODE) || (phase_v == jce_pkg::PH_CLOSED);
    run_push   = accept && ((acc.n != 2'd0) || closed);

    if (item.end_of_line) begin
      pfx_pos_nxt   = 3'd0;
      pfx_fail_nxt  = 1'b0;
      key_pos_nxt   = 4'd0;
      phase_nxt     = jce_pkg::PH_SEARCH;
      esc_nxt       = 1'b0;
      hex_cnt_nxt   = 3'd0;
      hex_chars_nxt = 24'd0;
      emit_cnt_nxt  = 16'd0;
      scan_esc_nxt  = 1'b0;
    end else begin
      phase_nxt     = phase_v;
      esc_nxt       = esc_v;
      hex_cnt_nxt   = hex_cnt_v;
      hex_chars_nxt = hex_chars_v;
      emit_cnt_nxt  = acc.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pfx_pos_r   <= 3'd0;
      pfx_fail_r  <= 1'b0;
      key_pos_r   <= 4'd0;
      phase_r     <= jce_pkg::PH_SEARCH;
      esc_r       <= 1'b0;
      hex_cnt_r   <= 3'd0;
      hex_chars_r <= 24'd0;
      emit_cnt_r  <= 16'd0;
      scan_esc_r  <= 1'b0;
    end else if (accept) begin
      pfx_pos_r   <= pfx_pos_nxt;
      pfx_fail_r  <= pfx_fail_nxt;
      key_pos_r   <= key_pos_nxt;
      phase_r     <= phase_nxt;
      esc_r       <= esc_nxt;
      hex_cnt_r   <= hex_cnt_nxt;
      hex_chars_r <= hex_chars_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      scan_esc_r  <= scan_esc_nxt;
    end
  end

endmodule

// File: hw/rtl/jce_run_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON content extractor run queue
// Short queue of result runs between the front end and the result sequencer.
// ----------------------------------------------------------------------------
module jce_run_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jce_pkg::run_t wdata,
  input  logic          pop,
  output jce_pkg::run_t rdata,
  output logic          full,
  output logic          not_empty
);

  jce_pkg::run_t               mem_r [jce_pkg::RUN_FIFO_DEPTH];
  logic [jce_pkg::RUN_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [jce_pkg::RUN_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [jce_pkg::RUN_PTR_W:0]   count_r, count_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign full      = (count_r == (jce_pkg::RUN_PTR_W + 1)'(jce_pkg::RUN_FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = do_push ? wptr_r + (jce_pkg::RUN_PTR_W)'(1) : wptr_r;
    rptr_nxt  = do_pop ? rptr_r + (jce_pkg::RUN_PTR_W)'(1) : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + (jce_pkg::RUN_PTR_W + 1)'(1);
    else if (do_pop && !do_push) count_nxt = count_r - (jce_pkg::RUN_PTR_W + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// File: hw/rtl/jce_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON content extractor result sequencer
// Walks the run at the head of the queue one result at a time into the
// output register.
// ----------------------------------------------------------------------------
module jce_back (
  input  logic          clk,
  input  logic          rst_n,
  input  jce_pkg::run_t head,
  input  logic          head_valid,
  output logic          head_pop,
  input  logic          out_pop,
  output logic          out_empty,
  output jce_pkg::out_t out_data
);

  logic          out_valid_r, out_valid_nxt;
  jce_pkg::out_t out_data_r, out_data_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic [1:0]    run_len;
  logic          last;
  logic          load;
  logic [7:0]    sel_byte;

  always_comb begin
    run_len = (head.n == 2'd0) ? 2'd1 : head.n;
    last    = (idx_r == run_len - 2'd1);
    load    = head_valid && (!out_valid_r || out_pop);
    case (idx_r)
      2'd0:    sel_byte = head.bytes[0];
      2'd1:    sel_byte = head.bytes[1];
      default: sel_byte = head.bytes[2];
    endcase
    head_pop = load && last;

    out_data_nxt.out_byte     = (head.n != 2'd0) ? sel_byte : 8'h00;
    out_data_nxt.byte_valid   = (head.n != 2'd0);
    out_data_nxt.content_done = last && head.closed;
    out_data_nxt.key_found    = head.key;
    out_data_nxt.last_of_run  = last;

    idx_nxt = idx_r;
    if (load) idx_nxt = last ? 2'd0 : idx_r + 2'd1;

    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_pop) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/tb_json_content_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON content extractor testbench
// Streams lines of bytes into the extractor under several register settings
// and checks every decoded result against an in-bench model of the decoder.
// ----------------------------------------------------------------------------
module tb_json_content_extractor;

  localparam string KEY_TEXT    = "\"content\":\"";
  localparam string PREFIX_TEXT = "data: ";

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_push = 1'b0;
  logic          in_full;
  jce_pkg::in_t  in_data = '0;
  logic          out_empty;
  logic          out_pop = 1'b0;
  jce_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic          cfg_index = 1'b0;
  logic [15:0]   cfg_wdata = '0;

  json_content_extractor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  jce_pkg::in_t  line_bytes_q[$];
  jce_pkg::out_t decoded_q[$];
  logic [7:0]    line_buf[$];
  int            queued_total = 0;
  int            mismatches = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  jce_pkg::out_t want_res;

  // Decoder model state.
  logic            m_mode = 1'b0;
  logic [15:0]     m_limit = jce_pkg::OUTPUT_LIMIT_RESET;
  int              prefix_pos = 0;
  bit              prefix_bad = 1'b0;
  int              key_pos = 0;
  jce_pkg::phase_t line_phase = jce_pkg::PH_SEARCH;
  bit              esc_pend = 1'b0;
  bit              quote_esc = 1'b0;
  int              hex_cnt = 0;
  logic [23:0]     hex_buf = '0;
  logic [15:0]     emit_cnt = '0;
  logic [7:0]      emit_buf[3];
  int              emit_num = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 100) begin
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  function automatic void line_reset();
    prefix_pos = 0;
    prefix_bad = 1'b0;
    key_pos = 0;
    line_phase = jce_pkg::PH_SEARCH;
    esc_pend = 1'b0;
    quote_esc = 1'b0;
    hex_cnt = 0;
    hex_buf = '0;
    emit_cnt = '0;
  endfunction

  function automatic void put_byte(input logic [7:0] v);
    if (emit_num < 3) begin
      emit_buf[emit_num] = v;
      emit_num++;
      emit_cnt++;
    end
  endfunction

  function automatic int next_key_pos(input int p, input logic [7:0] b);
    if (p < jce_pkg::KEY_LEN && b == KEY_TEXT[p]) return p + 1;
    if (p == 9 && b == "c") return 2;
    return (b == jce_pkg::CH_QUOTE) ? 1 : 0;
  endfunction

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  function automatic void decode_plain(input logic [7:0] b, input bit allow_u);
    if (esc_pend) begin
      esc_pend = 1'b0;
      case (b)
        "n": put_byte(8'h0A);
        "r": put_byte(8'h0D);
        "t": put_byte(8'h09);
        "b": put_byte(8'h08);
        "f": put_byte(8'h0C);
        "u": begin
          if (allow_u) begin
            hex_cnt = 1;
            hex_buf = '0;
          end
        end
        default: put_byte(b);
      endcase
    end else if (b == jce_pkg::CH_BACKSLASH) begin
      esc_pend = 1'b1;
    end else begin
      put_byte(b);
    end
  endfunction

  // A unicode escape cut short by the end of the string: replay what was gathered.
  function automatic void flush_unicode();
    int n;
    logic [7:0] ch;
    if (hex_cnt == 0) return;
    n = (hex_cnt - 1) & 3;
    hex_cnt = 0;
    for (int k = 0; k < n; k++) begin
      ch = 8'(hex_buf >> (8 * (n - 1 - k)));
      if (emit_cnt < m_limit) decode_plain(ch, 1'b0);
    end
  endfunction

  function automatic void finish_unicode(input logic [7:0] last);
    logic [7:0] d[4];
    logic [15:0] cp;
    int v;
    bit stop;
    d[0] = hex_buf[23:16];
    d[1] = hex_buf[15:8];
    d[2] = hex_buf[7:0];
    d[3] = last;
    hex_cnt = 0;
    cp = '0;
    stop = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!stop) begin
        v = hex_nibble(d[i]);
        if (v < 0) stop = 1'b1;
        else cp = {cp[11:0], 4'(v)};
      end
    end
    if (cp < jce_pkg::UTF8_ONE_LIMIT) begin
      put_byte(cp[7:0]);
    end else if (cp < jce_pkg::UTF8_TWO_LIMIT) begin
      if (int'(emit_cnt) + 2 < int'(m_limit)) begin
        put_byte(jce_pkg::UTF8_LEAD2 | 8'(cp >> 6));
        put_byte(jce_pkg::UTF8_CONT | {2'b00, cp[5:0]});
      end
    end else if (int'(emit_cnt) + 3 < int'(m_limit)) begin
      put_byte(jce_pkg::UTF8_LEAD3 | 8'(cp >> 12));
      put_byte(jce_pkg::UTF8_CONT | {2'b00, cp[11:6]});
      put_byte(jce_pkg::UTF8_CONT | {2'b00, cp[5:0]});
    end
  endfunction

  function automatic bit decode_content(input logic [7:0] b);
    bit ends;
    ends = (b == jce_pkg::CH_NUL) || (!quote_esc && b == jce_pkg::CH_QUOTE);
    if (quote_esc) quote_esc = 1'b0;
    else if (b == jce_pkg::CH_BACKSLASH) quote_esc = 1'b1;
    if (ends) begin
      flush_unicode();
      line_phase = jce_pkg::PH_CLOSED;
      return 1'b1;
    end
    if (hex_cnt != 0) begin
      if (hex_cnt < 4) begin
        hex_buf = {hex_buf[15:0], b};
        hex_cnt++;
      end else begin
        finish_unicode(b);
      end
    end else if (emit_cnt < m_limit) begin
      decode_plain(b, 1'b1);
    end
    return 1'b0;
  endfunction

  function automatic void extract_step(input jce_pkg::in_t item);
    logic [7:0] b;
    bit closed;
    bit key;
    int p;
    jce_pkg::out_t r;
    b = item.in_byte;
    closed = 1'b0;
    emit_num = 0;
    if (line_phase == jce_pkg::PH_SEARCH) begin
      if (m_mode && !prefix_bad && prefix_pos < jce_pkg::PREFIX_LEN) begin
        if (b == PREFIX_TEXT[prefix_pos]) prefix_pos++;
        else prefix_bad = 1'b1;
      end else if (!m_mode || !prefix_bad) begin
        if (b == jce_pkg::CH_NUL) begin
          line_phase = jce_pkg::PH_ENDED;
        end else begin
          p = next_key_pos(key_pos, b);
          if (p >= jce_pkg::KEY_LEN) begin
            key_pos = 0;
            line_phase = jce_pkg::PH_DECODE;
            esc_pend = 1'b0;
            quote_esc = 1'b0;
            hex_cnt = 0;
            hex_buf = '0;
          end else begin
            key_pos = p;
          end
        end
      end
    end else if (line_phase == jce_pkg::PH_DECODE) begin
      closed = decode_content(b);
    end
    if (item.end_of_line) begin
      if (line_phase == jce_pkg::PH_DECODE) flush_unicode();
      closed = 1'b1;
    end
    key = (line_phase == jce_pkg::PH_DECODE) || (line_phase == jce_pkg::PH_CLOSED);
    for (int k = 0; k < emit_num; k++) begin
      r.out_byte     = emit_buf[k];
      r.byte_valid   = 1'b1;
      r.content_done = closed && (k == emit_num - 1);
      r.key_found    = key;
      r.last_of_run  = (k == emit_num - 1);
      decoded_q.push_back(r);
    end
    if (closed && emit_num == 0) begin
      r = '0;
      r.content_done = 1'b1;
      r.key_found    = key;
      r.last_of_run  = 1'b1;
      decoded_q.push_back(r);
    end
    if (item.end_of_line) line_reset();
  endfunction

  function automatic void push_text(input string t);
    for (int i = 0; i < t.len(); i++) line_buf.push_back(t[i]);
  endfunction

  function automatic void queue_line();
    jce_pkg::in_t item;
    if (line_buf.size() == 0) line_buf.push_back(8'($urandom_range(1, 255)));
    foreach (line_buf[i]) begin
      item.in_byte     = line_buf[i];
      item.end_of_line = (i == line_buf.size() - 1);
      line_bytes_q.push_back(item);
    end
    queued_total += line_buf.size();
    line_buf.delete();
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 10) return 8'h30 + v;
    return (upper ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h20, 8'h7E));
    if (c == jce_pkg::CH_QUOTE || c == jce_pkg::CH_BACKSLASH) c = "a";
    return c;
  endfunction

  function automatic void push_unicode(input int ndig);
    logic [15:0] v;
    case ($urandom_range(2))
      0: v = 16'($urandom_range(0, 16'h7F));
      1: v = 16'($urandom_range(16'h80, 16'h7FF));
      default: v = 16'($urandom_range(16'h800, 16'hFFFF));
    endcase
    push_text("\\u");
    for (int i = 0; i < ndig; i++) begin
      line_buf.push_back(hex_char(v[15 - 4 * i -: 4], $urandom_range(1)));
    end
  endfunction

  function automatic void push_token();
    string mixed;
    string escs;
    int k;
    mixed = "0123456789aFGz\\\" ";
    escs = "nrtbf\\\"/q";
    case ($urandom_range(9))
      3: line_buf.push_back(8'($urandom_range(1, 255)));
      4: begin
        line_buf.push_back(jce_pkg::CH_BACKSLASH);
        line_buf.push_back(escs[$urandom_range(escs.len() - 1)]);
      end
      5, 6: push_unicode(4);
      7: begin
        push_text("\\u");
        repeat (4) line_buf.push_back(mixed[$urandom_range(mixed.len() - 1)]);
      end
      8: begin
        k = $urandom_range(3);
        push_unicode(k);
        repeat (4 - k) line_buf.push_back(plain_char());
      end
      default: line_buf.push_back(plain_char());
    endcase
  endfunction

  function automatic void gen_line(input bit esm);
    int pos;
    if (esm) begin
      push_text(PREFIX_TEXT);
      if ($urandom_range(9) < 2) begin
        pos = $urandom_range(5);
        line_buf[pos] = line_buf[pos] ^ 8'($urandom_range(1, 255));
      end
    end
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(2)) begin
        case ($urandom_range(3))
          0: line_buf.push_back(plain_char());
          1: push_text("\"con");
          2: push_text("\"content\"c");
          default: push_text("\"content\":");
        endcase
      end
      if ($urandom_range(9) != 0) push_text(KEY_TEXT);
      repeat ($urandom_range(6)) push_token();
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          line_buf.push_back(jce_pkg::CH_QUOTE);
          if ($urandom_range(3) == 0) push_text(KEY_TEXT);
          repeat ($urandom_range(3)) line_buf.push_back(8'($urandom_range(255)));
        end
        5: begin
          line_buf.push_back(jce_pkg::CH_NUL);
          repeat ($urandom_range(3)) line_buf.push_back(8'($urandom_range(255)));
        end
        6, 7: begin
          push_unicode($urandom_range(3));
          if ($urandom_range(1)) line_buf.push_back(jce_pkg::CH_QUOTE);
        end
        default: ;
      endcase
    end
    queue_line();
  endfunction

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == jce_pkg::REG_EVENT_STREAM_MODE) m_mode = val[0];
    else m_limit = val;
  endtask

  task automatic settle();
    while (line_bytes_q.size() != 0 || in_push || decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Input side: one byte offered at a time, held until its transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) extract_step(in_data);
      if (!in_push || !in_full) begin
        if (line_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= line_bytes_q.pop_front();
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Result side: every transfer is checked against the oldest decoded result.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result", int'(out_data), 0);
        end else begin
          want_res = decoded_q.pop_front();
          if (out_data.out_byte !== want_res.out_byte)
            report_mismatch("out_byte", out_data.out_byte, want_res.out_byte);
          if (out_data.byte_valid !== want_res.byte_valid)
            report_mismatch("byte_valid", out_data.byte_valid, want_res.byte_valid);
          if (out_data.content_done !== want_res.content_done)
            report_mismatch("content_done", out_data.content_done, want_res.content_done);
          if (out_data.key_found !== want_res.key_found)
            report_mismatch("key_found", out_data.key_found, want_res.key_found);
          if (out_data.last_of_run !== want_res.last_of_run)
            report_mismatch("last_of_run", out_data.last_of_run, want_res.last_of_run);
        end
      end
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : main
    int start;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = (ph < 3) ? 14 : (ph < 6) ? 59 : 0;
      recv_idle_pct = (ph < 3) ? 59 : (ph < 6) ? 14 : 0;
      case (ph)
        0: begin
          push_text("\"content\":\"\\u20ac\\n\\t\\\"");
          line_buf.push_back(8'hFF);
          line_buf.push_back(jce_pkg::CH_QUOTE);
          queue_line();
          line_buf.push_back(jce_pkg::CH_NUL);
          queue_line();
          push_text("x");
          queue_line();
        end
        1: begin
          write_reg(jce_pkg::REG_EVENT_STREAM_MODE, 16'd1);
          write_reg(jce_pkg::REG_OUTPUT_LIMIT, 16'hFFFF);
        end
        2: begin
          write_reg(jce_pkg::REG_EVENT_STREAM_MODE, 16'd0);
          write_reg(jce_pkg::REG_OUTPUT_LIMIT, 16'd1);
        end
        3: begin
          write_reg(jce_pkg::REG_EVENT_STREAM_MODE, 16'd1);
          write_reg(jce_pkg::REG_OUTPUT_LIMIT, 16'd5);
        end
        4: begin
          write_reg(jce_pkg::REG_EVENT_STREAM_MODE, 16'd0);
          write_reg(jce_pkg::REG_OUTPUT_LIMIT, 16'd4);
        end
        5: begin
          write_reg(jce_pkg::REG_EVENT_STREAM_MODE, 16'd1);
          write_reg(jce_pkg::REG_OUTPUT_LIMIT, 16'($urandom_range(1, 12)));
        end
        6: begin
          write_reg(jce_pkg::REG_EVENT_STREAM_MODE, 16'd0);
          write_reg(jce_pkg::REG_OUTPUT_LIMIT, 16'hFFFF);
        end
        default: begin
          write_reg(jce_pkg::REG_OUTPUT_LIMIT, 16'($urandom_range(2, 10)));
        end
      endcase
      start = queued_total;
      while (queued_total - start < 28) gen_line(m_mode);
      settle();
    end
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
